// ----- rtl/frx_pkg.sv -----
// shared types and codes for the framed packet receiver
package frx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned CfgIdxW = 2;

  // frame phases
  localparam logic [PhaseW-1:0] PH_START = 3'd0;
  localparam logic [PhaseW-1:0] PH_TYPE  = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN   = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA  = 3'd3;
  localparam logic [PhaseW-1:0] PH_CHECK = 3'd4;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE  = 3'd0;
  localparam logic [ErrW-1:0] ERR_START = 3'd1;
  localparam logic [ErrW-1:0] ERR_TYPE  = 3'd2;
  localparam logic [ErrW-1:0] ERR_LEN   = 3'd3;
  localparam logic [ErrW-1:0] ERR_CHECK = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_FLOOR   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_CEILING = 2'd2;

  // reset values, check seed and reserved length code
  localparam logic [ByteW-1:0] START_MARKER_RST = 8'hAA;
  localparam logic [ByteW-1:0] TYPE_FLOOR_RST   = 8'h00;
  localparam logic [ByteW-1:0] TYPE_CEILING_RST = 8'hFF;
  localparam logic [ByteW-1:0] CHECK_SEED       = 8'hFF;
  localparam logic [ByteW-1:0] LEN_INVALID      = 8'hFF;

  typedef struct packed {
    logic [ByteW-1:0]  byte_value;
    logic              store_byte;
    logic              frame_good;
    logic              frame_abort;
    logic [ErrW-1:0]   error_code;
    logic [PhaseW-1:0] phase_now;
  } frx_result_t;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] type_floor;
    logic [ByteW-1:0] type_ceiling;
  } frx_cfg_t;

endpackage

// ----- rtl/framed_packet_receiver_xor_check.sv -----
// top level of the framed packet receiver with xor check byte
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+-----------------
//  in_     | input     | in_rx_byte                              | in_valid/in_ready
//  out_    | output    | out_byte_value .. out_phase_now         | out_valid/out_ready
//  cfg_    | input     | cfg_index, cfg_data                     | cfg_valid/cfg_ready
//
// one word per cycle sustained while out_ready stays high; out_valid follows the input accept
// through two registers (input register, then frame logic into the result register)
// the feedback loop through the phase / count / check registers sets the rate
// synchronous active-low reset: wait for a start word, check seed 0xff, reset config
// a stall on out_ready backs up through the input register; no word is dropped
// cfg_ready is always high; writes belong in idle gaps with no word in flight
module framed_packet_receiver_xor_check
  import frx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input word channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   in_rx_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ByteW-1:0]   out_byte_value,
  output logic               out_store_byte,
  output logic               out_frame_good,
  output logic               out_frame_abort,
  output logic [ErrW-1:0]    out_error_code,
  output logic [PhaseW-1:0]  out_phase_now,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  // configuration registers
  frx_cfg_t cfg_r;

  // input register
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;

  // result register
  logic        out_valid_r;
  frx_result_t out_r;
  frx_result_t res;

  logic advance;
  logic out_free;

  // result register can take a new word when empty or being drained
  assign out_free = !out_valid_r || out_ready;
  // the word in the input register is processed and its state committed
  assign advance  = s1_valid_r && out_free;
  // input register accepts when empty or moving on this cycle
  assign in_ready = !s1_valid_r || advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= START_MARKER_RST;
      cfg_r.type_floor   <= TYPE_FLOOR_RST;
      cfg_r.type_ceiling <= TYPE_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_MARKER: cfg_r.start_marker <= cfg_data;
        CFG_TYPE_FLOOR:   cfg_r.type_floor   <= cfg_data;
        CFG_TYPE_CEILING: cfg_r.type_ceiling <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // frame phase logic with its state registers
  frx_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (s1_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_value  = out_r.byte_value;
  assign out_store_byte  = out_r.store_byte;
  assign out_frame_good  = out_r.frame_good;
  assign out_frame_abort = out_r.frame_abort;
  assign out_error_code  = out_r.error_code;
  assign out_phase_now   = out_r.phase_now;

endmodule

// ----- rtl/frx_step.sv -----
// frame state registers and per-word next-state logic
module frx_step
  import frx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [ByteW-1:0] rx_byte,
  input  frx_cfg_t         cfg,
  output frx_result_t      res
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [ByteW-1:0]  bytes_left_r, bytes_left_nxt;
  logic [ByteW-1:0]  running_check_r, running_check_nxt;
  logic [ByteW-1:0]  left_dec;

  assign left_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    bytes_left_nxt    = bytes_left_r;
    running_check_nxt = running_check_r;
    res.byte_value    = rx_byte;
    res.store_byte    = 1'b0;
    res.frame_good    = 1'b0;
    res.frame_abort   = 1'b0;
    res.error_code    = ERR_NONE;
    case (phase_r)
      PH_START: begin
        if (rx_byte == cfg.start_marker) begin
          res.store_byte    = 1'b1;
          running_check_nxt = CHECK_SEED ^ rx_byte;
          phase_nxt         = PH_TYPE;
        end else begin
          res.error_code  = ERR_START;
          res.frame_abort = 1'b1;
          phase_nxt       = PH_START;
        end
      end
      PH_TYPE: begin
        if (rx_byte <= cfg.type_floor || rx_byte >= cfg.type_ceiling) begin
          res.error_code  = ERR_TYPE;
          res.frame_abort = 1'b1;
          phase_nxt       = PH_START;
        end else begin
          res.store_byte    = 1'b1;
          running_check_nxt = running_check_r ^ rx_byte;
          phase_nxt         = PH_LEN;
        end
      end
      PH_LEN: begin
        if (rx_byte == LEN_INVALID) begin
          res.error_code  = ERR_LEN;
          res.frame_abort = 1'b1;
          phase_nxt       = PH_START;
        end else begin
          res.store_byte    = 1'b1;
          running_check_nxt = running_check_r ^ rx_byte;
          bytes_left_nxt    = rx_byte;
          phase_nxt         = (rx_byte == '0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (bytes_left_r != '0) begin
          res.store_byte    = 1'b1;
          running_check_nxt = running_check_r ^ rx_byte;
          bytes_left_nxt    = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_CHECK;
          end
        end else begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte == running_check_r) begin
          res.store_byte = 1'b1;
          res.frame_good = 1'b1;
        end else begin
          res.error_code  = ERR_CHECK;
          res.frame_abort = 1'b1;
        end
        phase_nxt = PH_START;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
    res.phase_now = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      bytes_left_r    <= '0;
      running_check_r <= CHECK_SEED;
    end else if (advance) begin
      phase_r         <= phase_nxt;
      bytes_left_r    <= bytes_left_nxt;
      running_check_r <= running_check_nxt;
    end
  end

endmodule

// ----- tb/tb_framed_packet_receiver_xor_check.sv -----
// self-checking testbench for the framed packet receiver: directed table, then random frames
`timescale 1ns / 100ps

module tb_framed_packet_receiver_xor_check;
  import frx_pkg::*;

  // run control
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEG_COUNT    = 8;
  localparam int SEG_WORDS    = 112;
  localparam int BIG_LEN      = 254;

  // register index with no register behind it, writes must be ignored
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // idle percentages per pacing mode: none, sender, receiver, both
  localparam int SEND_IDLE  [4] = '{0, 47, 0, 33};
  localparam int RECV_STALL [4] = '{0, 0, 47, 33};

  typedef enum int {
    FK_GOOD,
    FK_BAD_TYPE,
    FK_BAD_LEN,
    FK_BAD_CHECK,
    FK_CUT,
    FK_NOISE
  } frame_kind_t;

  // one row of the directed table; typed rows carry their own expected status
  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    frx_result_t      res;
  } stim_row_t;

  localparam frx_result_t NO_RES = '0;
  localparam int DIR_ROWS = 24;

  // directed walk under reset settings (marker aa, type window 00..ff exclusive)
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // wrong start words at both extremes
    '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, ERR_START, PH_START}},
    '{8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, ERR_START, PH_START}},
    // start then type on the floor
    '{8'hAA, 1'b1, '{8'hAA, 1'b1, 1'b0, 1'b0, ERR_NONE, PH_TYPE}},
    '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, ERR_TYPE, PH_START}},
    // start then type on the ceiling
    '{8'hAA, 1'b1, '{8'hAA, 1'b1, 1'b0, 1'b0, ERR_NONE, PH_TYPE}},
    '{8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, ERR_TYPE, PH_START}},
    // lowest legal type, then the reserved length
    '{8'hAA, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, ERR_LEN, PH_START}},
    // zero length frame, highest legal type, good check
    '{8'hAA, 1'b0, NO_RES},
    '{8'hFE, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hAB, 1'b0, NO_RES},
    // two data words at the extremes, wrong check
    '{8'hAA, 1'b0, NO_RES},
    '{8'h05, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, ERR_CHECK, PH_START}},
    // one data word, good check
    '{8'hAA, 1'b0, NO_RES},
    '{8'h7F, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h3C, 1'b0, NO_RES},
    '{8'h17, 1'b0, NO_RES}
  };

  // dut inputs, all known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [ByteW-1:0]   in_rx_byte = '0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;

  // dut outputs
  logic               in_ready;
  logic               out_valid;
  logic [ByteW-1:0]   out_byte_value;
  logic               out_store_byte;
  logic               out_frame_good;
  logic               out_frame_abort;
  logic [ErrW-1:0]    out_error_code;
  logic [PhaseW-1:0]  out_phase_now;
  logic               cfg_ready;

  // side band that travels with each input word: typed expectation from the table
  logic               dir_typed = 1'b0;
  frx_result_t        dir_res = '0;

  // pacing knobs set by the sequencer
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // scoreboard
  frx_result_t want_status_q [$];
  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_good     = 0;
  int n_abort    = 0;
  int n_settings = 1;
  int seg_words  = 0;

  // predictor copy of the block state and registers
  logic [ByteW-1:0]  marker_q;
  logic [ByteW-1:0]  floor_q;
  logic [ByteW-1:0]  ceil_q;
  logic [PhaseW-1:0] ph_q;
  logic [ByteW-1:0]  left_q;
  logic [ByteW-1:0]  chk_q;

  // sequencer copy of the current setting, used to shape frames
  logic [ByteW-1:0]  marker_s = START_MARKER_RST;
  logic [ByteW-1:0]  floor_s  = TYPE_FLOOR_RST;
  logic [ByteW-1:0]  ceil_s   = TYPE_CEILING_RST;

  framed_packet_receiver_xor_check u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_value  (out_byte_value),
    .out_store_byte  (out_store_byte),
    .out_frame_good  (out_frame_good),
    .out_frame_abort (out_frame_abort),
    .out_error_code  (out_error_code),
    .out_phase_now   (out_phase_now),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // frame status for one word; advances the predictor state
  function automatic frx_result_t predict_status(input logic [ByteW-1:0] b);
    frx_result_t r;
    r = '0;
    r.byte_value = b;
    r.error_code = ERR_NONE;
    case (ph_q)
      PH_START: begin
        if (b == marker_q) begin
          r.store_byte = 1'b1;
          chk_q = CHECK_SEED ^ b;
          ph_q = PH_TYPE;
        end else begin
          r.error_code = ERR_START;
          r.frame_abort = 1'b1;
          ph_q = PH_START;
        end
      end
      PH_TYPE: begin
        if (b <= floor_q || b >= ceil_q) begin
          r.error_code = ERR_TYPE;
          r.frame_abort = 1'b1;
          ph_q = PH_START;
        end else begin
          r.store_byte = 1'b1;
          chk_q = chk_q ^ b;
          ph_q = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b == LEN_INVALID) begin
          r.error_code = ERR_LEN;
          r.frame_abort = 1'b1;
          ph_q = PH_START;
        end else begin
          r.store_byte = 1'b1;
          chk_q = chk_q ^ b;
          left_q = b;
          ph_q = (b == '0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (left_q != '0) begin
          r.store_byte = 1'b1;
          chk_q = chk_q ^ b;
          left_q = left_q - 1'b1;
          if (left_q == '0) ph_q = PH_CHECK;
        end else begin
          // count already spent: word ignored, go to the check word
          ph_q = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // check accumulator is left as is, the next start word reloads it
        if (b == chk_q) begin
          r.store_byte = 1'b1;
          r.frame_good = 1'b1;
        end else begin
          r.error_code = ERR_CHECK;
          r.frame_abort = 1'b1;
        end
        ph_q = PH_START;
      end
      default: begin
        // undefined phase codes fall back to waiting for a start word
        ph_q = PH_START;
      end
    endcase
    r.phase_now = ph_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // monitor: register writes, accepted input words, accepted results
  always @(posedge clk) begin : mon
    frx_result_t pred;
    frx_result_t want;
    if (!rst_n) begin
      marker_q = START_MARKER_RST;
      floor_q  = TYPE_FLOOR_RST;
      ceil_q   = TYPE_CEILING_RST;
      ph_q     = PH_START;
      left_q   = '0;
      chk_q    = CHECK_SEED;
      want_status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_MARKER: marker_q = cfg_data;
          CFG_TYPE_FLOOR:   floor_q  = cfg_data;
          CFG_TYPE_CEILING: ceil_q   = cfg_data;
          default: ;
        endcase
      end
      // push before pop so a combinational path through the block would still line up
      if (in_valid && in_ready) begin
        pred = predict_status(in_rx_byte);
        if (pred.frame_good) n_good++;
        if (pred.frame_abort) n_abort++;
        want_status_q.push_back(dir_typed ? dir_res : pred);
      end
      if (out_valid && out_ready) begin
        if (want_status_q.size() == 0) begin
          $display("%0t unexpected result word %0h with nothing expected", $time,
                   out_byte_value);
          n_errors++;
        end else begin
          want = want_status_q.pop_front();
          check_field("byte_value",  want.byte_value,  out_byte_value);
          check_field("store_byte",  want.store_byte,  out_store_byte);
          check_field("frame_good",  want.frame_good,  out_frame_good);
          check_field("frame_abort", want.frame_abort, out_frame_abort);
          check_field("error_code",  want.error_code,  out_error_code);
          check_field("phase_now",   want.phase_now,   out_phase_now);
          n_checked++;
        end
      end
    end
  end

  // one input word, with random idle cycles in front of it
  task automatic send_word(input logic [ByteW-1:0] b, input logic typed,
                           input frx_result_t res);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    dir_typed  <= typed;
    dir_res    <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    seg_words++;
  endtask

  // hold the input low until every expected status word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (n_checked != n_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // block must be idle here; writes all three registers back to back
  task automatic apply_setting(input logic [ByteW-1:0] m, input logic [ByteW-1:0] f,
                               input logic [ByteW-1:0] c);
    write_reg(CFG_START_MARKER, m);
    write_reg(CFG_TYPE_FLOOR, f);
    write_reg(CFG_TYPE_CEILING, c);
    cfg_valid <= 1'b0;
    marker_s = m;
    floor_s  = f;
    ceil_s   = c;
    n_settings++;
    @(posedge clk);
  endtask

  // one frame of the given kind; broken kinds stop right after the bad word
  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [ByteW-1:0] words [$];
    logic [ByteW-1:0] ty;
    logic [ByteW-1:0] chk;
    int keep;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(4, 1)) words.push_back(ByteW'($urandom_range(255)));
    end else begin
      if (kind == FK_BAD_TYPE) begin
        // at or below the floor, or at or above the ceiling
        if ($urandom_range(1) == 0) ty = ByteW'($urandom_range(floor_s, 0));
        else ty = ByteW'($urandom_range(255, ceil_s));
      end else if (int'(ceil_s) > int'(floor_s) + 1) begin
        ty = ByteW'($urandom_range(int'(ceil_s) - 1, int'(floor_s) + 1));
      end else begin
        // empty type window, any type is rejected
        ty = ByteW'($urandom_range(255));
      end
      words.push_back(marker_s);
      words.push_back(ty);
      if (kind == FK_BAD_LEN) begin
        words.push_back(LEN_INVALID);
      end else if (kind != FK_BAD_TYPE) begin
        words.push_back(ByteW'(len));
        repeat (len) words.push_back(ByteW'($urandom_range(255)));
        chk = CHECK_SEED;
        foreach (words[i]) chk = chk ^ words[i];
        if (kind == FK_BAD_CHECK) chk = chk ^ ByteW'($urandom_range(255, 1));
        words.push_back(chk);
        if (kind == FK_CUT) begin
          // frame dropped part way, the next frame lands in the middle of it
          keep = $urandom_range(words.size() - 1, 1);
          while (words.size() > keep) void'(words.pop_back());
        end
      end
    end
    foreach (words[i]) send_word(words[i], 1'b0, NO_RES);
  endtask

  task automatic send_random_frame();
    int r;
    int len;
    frame_kind_t kind;
    r = $urandom_range(99);
    // mostly short frames, now and then a longer one
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
    if (r < 68)      kind = FK_GOOD;
    else if (r < 76) kind = FK_BAD_TYPE;
    else if (r < 81) kind = FK_BAD_LEN;
    else if (r < 88) kind = FK_BAD_CHECK;
    else if (r < 94) kind = FK_CUT;
    else             kind = FK_NOISE;
    send_frame(kind, len);
  endtask

  // main sequence
  initial begin : seq
    int seg;
    bit paused;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under reset settings, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(DIR_TAB[i].rx, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    // random segments: two settings per pacing mode
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg != 0) begin
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        case (seg)
          1: apply_setting(8'h00, 8'h00, 8'hFF);
          // only one legal type
          2: apply_setting(8'hFF, 8'h7F, 8'h81);
          3: begin
            write_reg(CFG_UNUSED, ByteW'($urandom_range(255)));
            apply_setting(ByteW'($urandom_range(255)), ByteW'($urandom_range(100)),
                          ByteW'($urandom_range(255, 150)));
          end
          // floor above ceiling, every type is rejected
          4: apply_setting(8'h55, 8'hFF, 8'h00);
          5: apply_setting(ByteW'($urandom_range(255)), 8'h00, 8'hFF);
          6: apply_setting(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                           ByteW'($urandom_range(255)));
          default: apply_setting(START_MARKER_RST, TYPE_FLOOR_RST, TYPE_CEILING_RST);
        endcase
      end
      send_idle_pct  = SEND_IDLE[seg / 2];
      recv_stall_pct = RECV_STALL[seg / 2];
      seg_words = 0;
      paused = 1'b0;
      // longest legal frame once
      if (seg == 5) send_frame(FK_GOOD, BIG_LEN);
      while (seg_words < SEG_WORDS) begin
        // sender holds off mid segment until the pipe is empty
        if (!paused && seg_words >= SEG_WORDS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        send_random_frame();
      end
    end

    // final drain, then a check that nothing stray is still expected
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_status_q.size() != 0) begin
      $display("%0t %0d expected status words never arrived", $time, want_status_q.size());
      n_errors++;
    end

    $display("ran %0d words over %0d register settings and four pacing modes",
             n_sent, n_settings);
    $display("frames committed %0d, aborts flagged %0d, mismatches %0d",
             n_good, n_abort, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t watchdog expired", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- framed_packet_receiver_xor_check.f -----
rtl/frx_pkg.sv
rtl/frx_step.sv
rtl/framed_packet_receiver_xor_check.sv
tb/tb_framed_packet_receiver_xor_check.sv
